// ===== rtl/drd_pkg.sv =====
// Shared types, constants and codes of the dead reckoning distance block.
// Depends on nothing; every other file takes names from here by scope.
package drd_pkg;

   localparam int SAMPLE_BITS_DEF = 12;

   localparam int BIAS_W    = 20;
   localparam int GAIN_W    = 20;
   localparam int STEP_W    = 32;
   localparam int THR_W     = 28;
   localparam int ACC_W     = 32;
   localparam int STATE_W   = 64;
   localparam int OUT_W     = 32;
   localparam int MUL_W     = 33;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // raw * gain carries 8 extra fraction bits, acc * dt carries 16
   localparam int GAIN_SHIFT = 8;
   localparam int VEL_SHIFT  = 16;
   localparam int POS_SHIFT  = 32;
   localparam int OUT_SHIFT  = 16;

   localparam logic signed [BIAS_W-1:0] BIAS_X_RST      = 20'sd355;
   localparam logic signed [BIAS_W-1:0] BIAS_Y_RST      = -20'sd114;
   localparam logic        [GAIN_W-1:0] ACCEL_GAIN_RST  = 20'd30615;
   localparam logic        [STEP_W-1:0] TIME_STEP_RST   = 32'd35791394;
   localparam logic signed [THR_W-1:0]  START_THR_RST   = -28'sd104858;
   localparam logic signed [THR_W-1:0]  STOP_THR_RST    = 28'sd196608;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BIAS_X     = 3'd0,
      REG_BIAS_Y     = 3'd1,
      REG_ACCEL_GAIN = 3'd2,
      REG_TIME_STEP  = 3'd3,
      REG_START_THR  = 3'd4,
      REG_STOP_THR   = 3'd5
   } csr_reg_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_START = 2'd1,
      EV_END   = 2'd2
   } event_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCL_X,
      ST_SCL_Y,
      ST_DECIDE,
      ST_VEL_Y,
      ST_PHI_X,
      ST_PLO_X,
      ST_PHI_Y,
      ST_PLO_Y,
      ST_POS_Y,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic signed [BIAS_W-1:0] bias_x;
      logic signed [BIAS_W-1:0] bias_y;
      logic        [GAIN_W-1:0] accel_gain;
      logic        [STEP_W-1:0] time_step;
      logic signed [THR_W-1:0]  start_threshold;
      logic signed [THR_W-1:0]  stop_threshold;
   } cfg_type;

   typedef struct packed {
      logic                    measuring;
      event_type               event_res;
      logic signed [OUT_W-1:0] distance;
      logic signed [OUT_W-1:0] lateral_position;
   } rsp_type;

endpackage

// ===== rtl/drd_if.sv =====
// Channel interfaces of the dead reckoning distance block: samples in,
// results out, register writes. Depends on drd_pkg for widths and codes.
interface drd_req_if #(
   parameter int SAMPLE_BITS = drd_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_x;
   logic signed [SAMPLE_BITS-1:0] sample_y;

   modport source (output valid, output sample_x, output sample_y, input ready);
   modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface drd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              measuring;
   logic [1:0]                        event_res;
   logic signed [drd_pkg::OUT_W-1:0]  distance;
   logic signed [drd_pkg::OUT_W-1:0]  lateral_position;

   modport source (output valid, output measuring, output event_res, output distance,
                   output lateral_position, input ready);
   modport sink   (input valid, input measuring, input event_res, input distance,
                   input lateral_position, output ready);
endinterface

interface drd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [drd_pkg::CSR_IDX_W-1:0]     index;
   logic [drd_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/drd_csr.sv =====
// Configuration registers of the dead reckoning distance block.
// Depends on drd_pkg for register codes, reset values and the cfg struct.
module drd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [drd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [drd_pkg::CSR_DATA_W-1:0]   csr_data,
   output drd_pkg::cfg_type                 cfg
);

   drd_pkg::cfg_type cfg_ff;
   drd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // keep the low bits of the write data; drop writes to unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (drd_pkg::csr_reg_type'(csr_index))
            drd_pkg::REG_BIAS_X:     cfg_in.bias_x          = signed'(csr_data[drd_pkg::BIAS_W-1:0]);
            drd_pkg::REG_BIAS_Y:     cfg_in.bias_y          = signed'(csr_data[drd_pkg::BIAS_W-1:0]);
            drd_pkg::REG_ACCEL_GAIN: cfg_in.accel_gain      = csr_data[drd_pkg::GAIN_W-1:0];
            drd_pkg::REG_TIME_STEP:  cfg_in.time_step       = csr_data[drd_pkg::STEP_W-1:0];
            drd_pkg::REG_START_THR:  cfg_in.start_threshold = signed'(csr_data[drd_pkg::THR_W-1:0]);
            drd_pkg::REG_STOP_THR:   cfg_in.stop_threshold  = signed'(csr_data[drd_pkg::THR_W-1:0]);
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bias_x          <= drd_pkg::BIAS_X_RST;
         cfg_ff.bias_y          <= drd_pkg::BIAS_Y_RST;
         cfg_ff.accel_gain      <= drd_pkg::ACCEL_GAIN_RST;
         cfg_ff.time_step       <= drd_pkg::TIME_STEP_RST;
         cfg_ff.start_threshold <= drd_pkg::START_THR_RST;
         cfg_ff.stop_threshold  <= drd_pkg::STOP_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/drd_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on drd_pkg for operand and product widths.
module drd_mul (
   input  logic                              clock,
   input  logic signed [drd_pkg::MUL_W-1:0]  mul_a,
   input  logic signed [drd_pkg::MUL_W-1:0]  mul_b,
   output logic signed [drd_pkg::PROD_W-1:0] product
);

   logic signed [drd_pkg::PROD_W-1:0] product_ff;
   logic signed [drd_pkg::PROD_W-1:0] product_in;

   assign product_in = drd_pkg::PROD_W'(mul_a) * drd_pkg::PROD_W'(mul_b);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== rtl/drd_core.sv =====
// Sequencer and datapath: scaling, double integration, mode and result register.
// Depends on drd_pkg; drives the shared multiplier in drd_mul.
module drd_core #(
   parameter int SAMPLE_BITS = drd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  drd_pkg::cfg_type                  cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_BITS-1:0]     sample_x,
   input  logic signed [SAMPLE_BITS-1:0]     sample_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output drd_pkg::rsp_type                  rsp,
   output logic signed [drd_pkg::MUL_W-1:0]  mul_a,
   output logic signed [drd_pkg::MUL_W-1:0]  mul_b,
   input  logic signed [drd_pkg::PROD_W-1:0] product
);

   localparam int SHIFTED_W = SAMPLE_BITS + drd_pkg::GAIN_SHIFT;
   localparam int D_W = ((SHIFTED_W > drd_pkg::BIAS_W) ? SHIFTED_W : drd_pkg::BIAS_W) + 1;
   localparam int PW  = drd_pkg::PROD_W;
   localparam int SW  = drd_pkg::STATE_W;
   localparam int AW  = drd_pkg::ACC_W;

   function automatic logic signed [AW-1:0] sat_acc(input logic signed [PW-1:0] v);
      logic signed [AW-1:0] r;
      if (&v[PW-1:AW-1] || ~|v[PW-1:AW-1]) begin
         r = v[AW-1:0];
      end else if (v[PW-1]) begin
         r = {1'b1, {(AW-1){1'b0}}};
      end else begin
         r = {1'b0, {(AW-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [SW-1:0] sat_state(input logic signed [PW-1:0] v);
      logic signed [SW-1:0] r;
      if (&v[PW-1:SW-1] || ~|v[PW-1:SW-1]) begin
         r = v[SW-1:0];
      end else if (v[PW-1]) begin
         r = {1'b1, {(SW-1){1'b0}}};
      end else begin
         r = {1'b0, {(SW-1){1'b1}}};
      end
      return r;
   endfunction

   drd_pkg::state_type state_ff, state_in;

   logic                  mode_ff;
   drd_pkg::event_type    ev_ff;
   logic                  rsp_valid_ff;
   logic signed [D_W-1:0] dx_ff, dy_ff;
   logic signed [AW-1:0]  acc_x_ff, acc_y_ff;
   logic signed [SW-1:0]  vel_x_ff, vel_y_ff, pos_x_ff, pos_y_ff;
   logic signed [PW-1:0]  part_ff;
   drd_pkg::rsp_type      rsp_ff, rsp_in;

   logic                  load;
   logic signed [D_W-1:0] dx_in, dy_in;
   logic signed [AW-1:0]  acc_new;
   logic signed [SW-1:0]  vel_old, pos_old;
   logic signed [PW-1:0]  vel_sum, part_sum, pos_sum;
   logic signed [PW-1:0]  dist_full, lat_full;
   logic                  start_hit, stop_hit;
   logic signed [drd_pkg::MUL_W-1:0] gain_op, step_op;

   assign req_ready = (state_ff == drd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // bias removal at the input, raw counts with 8 fraction bits
   assign dx_in = (D_W'(sample_x) <<< drd_pkg::GAIN_SHIFT) - D_W'(cfg.bias_x);
   assign dy_in = (D_W'(sample_y) <<< drd_pkg::GAIN_SHIFT) - D_W'(cfg.bias_y);

   assign gain_op = signed'(drd_pkg::MUL_W'(cfg.accel_gain));
   assign step_op = signed'(drd_pkg::MUL_W'(cfg.time_step));

   assign acc_new  = sat_acc(product >>> drd_pkg::GAIN_SHIFT);
   assign vel_old  = (state_ff == drd_pkg::ST_VEL_Y) ? vel_x_ff : vel_y_ff;
   assign vel_sum  = PW'(vel_old) + (product >>> drd_pkg::VEL_SHIFT);
   assign pos_old  = (state_ff == drd_pkg::ST_PLO_X) ? pos_x_ff : pos_y_ff;
   assign part_sum = PW'(pos_old) + product;
   assign pos_sum  = part_ff
                   + signed'(PW'(product[drd_pkg::POS_SHIFT +: drd_pkg::POS_SHIFT]));

   assign start_hit = acc_new  < AW'(cfg.start_threshold);
   assign stop_hit  = acc_y_ff > AW'(cfg.stop_threshold);

   assign dist_full = -(PW'(pos_y_ff) >>> drd_pkg::OUT_SHIFT);
   assign lat_full  = PW'(pos_x_ff) >>> drd_pkg::OUT_SHIFT;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drd_pkg::ST_IDLE:   if (req_valid) state_in = drd_pkg::ST_SCL_X;
         drd_pkg::ST_SCL_X:  state_in = drd_pkg::ST_SCL_Y;
         drd_pkg::ST_SCL_Y:  state_in = drd_pkg::ST_DECIDE;
         drd_pkg::ST_DECIDE: state_in = mode_ff ? drd_pkg::ST_VEL_Y : drd_pkg::ST_RESULT;
         drd_pkg::ST_VEL_Y:  state_in = drd_pkg::ST_PHI_X;
         drd_pkg::ST_PHI_X:  state_in = drd_pkg::ST_PLO_X;
         drd_pkg::ST_PLO_X:  state_in = drd_pkg::ST_PHI_Y;
         drd_pkg::ST_PHI_Y:  state_in = drd_pkg::ST_PLO_Y;
         drd_pkg::ST_PLO_Y:  state_in = drd_pkg::ST_POS_Y;
         drd_pkg::ST_POS_Y:  state_in = drd_pkg::ST_RESULT;
         drd_pkg::ST_RESULT: if (load) state_in = drd_pkg::ST_IDLE;
         default:            state_in = drd_pkg::ST_IDLE;
      endcase
   end

   // multiplier operands and result load
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      load  = 1'b0;
      unique case (state_ff)
         drd_pkg::ST_SCL_X: begin
            mul_a = drd_pkg::MUL_W'(dx_ff);
            mul_b = gain_op;
         end
         drd_pkg::ST_SCL_Y: begin
            mul_a = drd_pkg::MUL_W'(dy_ff);
            mul_b = gain_op;
         end
         drd_pkg::ST_DECIDE: begin
            mul_a = drd_pkg::MUL_W'(acc_x_ff);
            mul_b = step_op;
         end
         drd_pkg::ST_VEL_Y: begin
            mul_a = drd_pkg::MUL_W'(acc_y_ff);
            mul_b = step_op;
         end
         drd_pkg::ST_PHI_X: begin
            mul_a = drd_pkg::MUL_W'(signed'(vel_x_ff[SW-1:drd_pkg::POS_SHIFT]));
            mul_b = step_op;
         end
         drd_pkg::ST_PLO_X: begin
            mul_a = signed'(drd_pkg::MUL_W'(vel_x_ff[drd_pkg::POS_SHIFT-1:0]));
            mul_b = step_op;
         end
         drd_pkg::ST_PHI_Y: begin
            mul_a = drd_pkg::MUL_W'(signed'(vel_y_ff[SW-1:drd_pkg::POS_SHIFT]));
            mul_b = step_op;
         end
         drd_pkg::ST_PLO_Y: begin
            mul_a = signed'(drd_pkg::MUL_W'(vel_y_ff[drd_pkg::POS_SHIFT-1:0]));
            mul_b = step_op;
         end
         drd_pkg::ST_RESULT: load = !rsp_valid_ff || rsp_ready;
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      rsp_in.measuring        = mode_ff;
      rsp_in.event_res        = ev_ff;
      rsp_in.distance         = sat_acc(dist_full);
      rsp_in.lateral_position = sat_acc(lat_full);
   end

   // control state and integrators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drd_pkg::ST_IDLE;
         mode_ff      <= 1'b0;
         ev_ff        <= drd_pkg::EV_NONE;
         rsp_valid_ff <= 1'b0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            drd_pkg::ST_DECIDE: begin
               if (!mode_ff) begin
                  vel_x_ff <= '0;
                  vel_y_ff <= '0;
                  pos_x_ff <= '0;
                  pos_y_ff <= '0;
                  mode_ff  <= start_hit;
                  ev_ff    <= start_hit ? drd_pkg::EV_START : drd_pkg::EV_NONE;
               end
            end
            drd_pkg::ST_VEL_Y: vel_x_ff <= sat_state(vel_sum);
            drd_pkg::ST_PHI_X: vel_y_ff <= sat_state(vel_sum);
            drd_pkg::ST_PHI_Y: pos_x_ff <= sat_state(pos_sum);
            drd_pkg::ST_POS_Y: begin
               pos_y_ff <= sat_state(pos_sum);
               mode_ff  <= !stop_hit;
               ev_ff    <= stop_hit ? drd_pkg::EV_END : drd_pkg::EV_NONE;
            end
            default: begin
               ev_ff <= ev_ff;
            end
         endcase
      end
   end

   // operands, partial sums and the result payload
   always_ff @(posedge clock) begin
      case (state_ff)
         drd_pkg::ST_IDLE: begin
            dx_ff <= dx_in;
            dy_ff <= dy_in;
         end
         drd_pkg::ST_SCL_Y:  acc_x_ff <= acc_new;
         drd_pkg::ST_DECIDE: acc_y_ff <= acc_new;
         drd_pkg::ST_PLO_X:  part_ff  <= part_sum;
         drd_pkg::ST_PLO_Y:  part_ff  <= part_sum;
         drd_pkg::ST_RESULT: if (load) rsp_ff <= rsp_in;
         default:            part_ff  <= part_ff;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a sample is still in work");

   a_start_measures: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_res == drd_pkg::EV_START) |-> rsp_ff.measuring)
      else $error("start event without measuring mode");

   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_res == drd_pkg::EV_END) |-> !rsp_ff.measuring)
      else $error("end event while still measuring");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.measuring && rsp_ff.event_res == drd_pkg::EV_NONE)
      |-> (rsp_ff.distance == '0 && rsp_ff.lateral_position == '0))
      else $error("idle result with nonzero position");

   a_mode_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && mode_ff != $past(mode_ff))
      |-> ($past(state_ff) == drd_pkg::ST_DECIDE || $past(state_ff) == drd_pkg::ST_POS_Y))
      else $error("mode changed outside a decision step");
`endif

endmodule

// ===== rtl/accel_dead_reckoning_distance_top.sv =====
// Top level of the accelerometer dead reckoning distance block.
// Depends on drd_pkg, the channel interfaces, drd_csr, drd_mul and drd_core.

// Each transaction on req_chan is one raw two-axis sample; each yields one
// transaction on rsp_chan. All products go through one 33x33 signed multiplier
// with a registered output, stepped by a small sequencer, so the multiplier sets
// the rate: a sample in idle mode passes two scaling multiplies, a decision step
// and the result load before the next sample can be accepted; a sample in
// measuring mode passes two scaling, two velocity and four position multiplies.
// A result that is not taken stalls the sequencer in its last step; one result
// may wait in the output register while the next sample is still in work.
// csr_chan is always ready, and writes take effect on the next cycle; write
// only while no sample is in work. Writes to unknown indexes are dropped.
module accel_dead_reckoning_distance_top #(
   parameter int SAMPLE_BITS = drd_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   drd_req_if.sink     req_chan,
   drd_rsp_if.source   rsp_chan,
   drd_csr_if.sink     csr_chan
);

   drd_pkg::cfg_type                  cfg;
   drd_pkg::rsp_type                  rsp;
   logic signed [drd_pkg::MUL_W-1:0]  mul_a;
   logic signed [drd_pkg::MUL_W-1:0]  mul_b;
   logic signed [drd_pkg::PROD_W-1:0] product;
   logic signed [SAMPLE_BITS-1:0]     sample_x;
   logic signed [SAMPLE_BITS-1:0]     sample_y;

   // take only the low SAMPLE_BITS of each sample
   assign sample_x = SAMPLE_BITS'(req_chan.sample_x);
   assign sample_y = SAMPLE_BITS'(req_chan.sample_y);

   // register file: bias, gain, sample period and thresholds
   drd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .cfg       (cfg)
   );

   // shared multiplier; the product is consumed in the cycle after issue
   drd_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // sequencer, integrators, mode and the output register
   drd_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sample_x  (sample_x),
      .sample_y  (sample_y),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp       (rsp),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .product   (product)
   );

   // unpack the result onto the output channel
   assign rsp_chan.measuring        = rsp.measuring;
   assign rsp_chan.event_res        = rsp.event_res;
   assign rsp_chan.distance         = rsp.distance;
   assign rsp_chan.lateral_position = rsp.lateral_position;

endmodule
